// File: sv/bci_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the breakpoint curve interpolator.
// No dependencies; imported by the controller, the datapath and the top level.
package bci_pkg;

  localparam int MAX_POINTS = 64;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int POS_W      = 32;
  localparam int VAL_W      = 16;
  localparam int KIND_W     = 3;
  localparam int MODE_W     = 3;

  localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MOVE   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SETK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_EVAL   = 3'd5;

  localparam logic [KIND_W-1:0] KIND_STEP    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LINEAR  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_EASEIN  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_EASEOUT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SMOOTH  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_HOLD    = 3'd5;
  localparam logic [KIND_W-1:0] KIND_BEZIER  = 3'd6;
  localparam logic [KIND_W-1:0] KIND_HERMITE = 3'd7;

  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_NOMATCH = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;

  // datapath operation codes issued by the controller
  localparam logic [4:0] OP_NONE     = 5'd0;
  localparam logic [4:0] OP_LOAD     = 5'd1;
  localparam logic [4:0] OP_SCAN_RD  = 5'd2;
  localparam logic [4:0] OP_SCAN_CHK = 5'd3;
  localparam logic [4:0] OP_DECIDE   = 5'd4;
  localparam logic [4:0] OP_SH_RD    = 5'd5;
  localparam logic [4:0] OP_SH_WR    = 5'd6;
  localparam logic [4:0] OP_PUT      = 5'd7;
  localparam logic [4:0] OP_ER_RD    = 5'd8;
  localparam logic [4:0] OP_ER_WR    = 5'd9;
  localparam logic [4:0] OP_ER_END   = 5'd10;
  localparam logic [4:0] OP_EV_INIT  = 5'd11;
  localparam logic [4:0] OP_DIV      = 5'd12;
  localparam logic [4:0] OP_SQ       = 5'd13;
  localparam logic [4:0] OP_T2       = 5'd14;
  localparam logic [4:0] OP_WGT      = 5'd15;
  localparam logic [4:0] OP_BLEND    = 5'd16;
  localparam logic [4:0] OP_HMUL     = 5'd17;
  localparam logic [4:0] OP_HACC     = 5'd18;
  localparam logic [4:0] OP_EMIT     = 5'd19;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [31:0]       position;
    logic [31:0]       new_position;
    logic [15:0]       point_value;
    logic [2:0]        interp_kind;
    logic [31:0]       tolerance;
  } req_t;

  typedef struct packed {
    logic [15:0] curve_value;
    logic [1:0]  status;
    logic [6:0]  point_count;
  } res_t;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [VAL_W-1:0]  val;
    logic [KIND_W-1:0] kind;
  } entry_t;

  typedef struct packed {
    logic [4:0] op;
    logic [1:0] hsel;
  } cmd_t;

  typedef struct packed {
    logic is_insert;
    logic is_remove;
    logic is_move1;
    logic is_eval;
    logic exact;
    logic full;
    logic tol_ok;
    logic same_pos;
    logic interp;
    logic herm;
    logic at_ins;
    logic er_end;
    logic scan_end;
    logic div_last;
  } sts_t;

endpackage

// File: sv/bci_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences scan, shift, erase and evaluate steps.
// Depends on bci_pkg; drives the datapath through cmd_t, reads sts_t.
module bci_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  bci_pkg::sts_t sts,
  output bci_pkg::cmd_t cmd,
  output logic          busy
);
  import bci_pkg::*;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_SC_RD   = 5'd1;
  localparam logic [4:0] S_SC_CHK  = 5'd2;
  localparam logic [4:0] S_DECIDE  = 5'd3;
  localparam logic [4:0] S_SH_RD   = 5'd4;
  localparam logic [4:0] S_SH_WR   = 5'd5;
  localparam logic [4:0] S_ER_RD   = 5'd6;
  localparam logic [4:0] S_ER_WR   = 5'd7;
  localparam logic [4:0] S_EV_INIT = 5'd8;
  localparam logic [4:0] S_EV_DIV  = 5'd9;
  localparam logic [4:0] S_EV_SQ   = 5'd10;
  localparam logic [4:0] S_EV_T2   = 5'd11;
  localparam logic [4:0] S_EV_W    = 5'd12;
  localparam logic [4:0] S_EV_BL   = 5'd13;
  localparam logic [4:0] S_H0      = 5'd14;
  localparam logic [4:0] S_H1      = 5'd15;
  localparam logic [4:0] S_H2      = 5'd16;
  localparam logic [4:0] S_H3      = 5'd17;
  localparam logic [4:0] S_H4      = 5'd18;
  localparam logic [4:0] S_DONE    = 5'd19;

  logic [4:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    cmd.hsel  = 2'd0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_SC_RD;
        end
      end
      S_SC_RD: begin
        if (sts.scan_end) begin
          state_nxt = S_DECIDE;
        end else begin
          cmd.op    = OP_SCAN_RD;
          state_nxt = S_SC_CHK;
        end
      end
      S_SC_CHK: begin
        cmd.op    = OP_SCAN_CHK;
        state_nxt = S_SC_RD;
      end
      S_DECIDE: begin
        cmd.op = OP_DECIDE;
        priority if (sts.is_insert) begin
          state_nxt = (sts.exact || sts.full) ? S_DONE : S_SH_RD;
        end else if (sts.is_remove) begin
          state_nxt = sts.tol_ok ? S_ER_RD : S_DONE;
        end else if (sts.is_move1) begin
          state_nxt = (sts.exact && !sts.same_pos) ? S_ER_RD : S_DONE;
        end else if (sts.is_eval) begin
          state_nxt = sts.interp ? S_EV_INIT : S_DONE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SH_RD: begin
        if (sts.at_ins) begin
          cmd.op    = OP_PUT;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_SH_RD;
          state_nxt = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd.op    = OP_SH_WR;
        state_nxt = S_SH_RD;
      end
      S_ER_RD: begin
        if (sts.er_end) begin
          cmd.op    = OP_ER_END;
          // a move rescans for its target position after the erase
          state_nxt = sts.is_move1 ? S_SC_RD : S_DONE;
        end else begin
          cmd.op    = OP_ER_RD;
          state_nxt = S_ER_WR;
        end
      end
      S_ER_WR: begin
        cmd.op    = OP_ER_WR;
        state_nxt = S_ER_RD;
      end
      S_EV_INIT: begin
        cmd.op    = OP_EV_INIT;
        state_nxt = S_EV_DIV;
      end
      S_EV_DIV: begin
        cmd.op = OP_DIV;
        if (sts.div_last) begin
          state_nxt = S_EV_SQ;
        end
      end
      S_EV_SQ: begin
        cmd.op    = OP_SQ;
        state_nxt = S_EV_T2;
      end
      S_EV_T2: begin
        cmd.op    = OP_T2;
        state_nxt = S_EV_W;
      end
      S_EV_W: begin
        cmd.op    = OP_WGT;
        state_nxt = sts.herm ? S_H0 : S_EV_BL;
      end
      S_EV_BL: begin
        cmd.op    = OP_BLEND;
        state_nxt = S_DONE;
      end
      S_H0: begin
        cmd.op    = OP_HMUL;
        cmd.hsel  = 2'd0;
        state_nxt = S_H1;
      end
      S_H1: begin
        cmd.op    = OP_HMUL;
        cmd.hsel  = 2'd1;
        state_nxt = S_H2;
      end
      S_H2: begin
        cmd.op    = OP_HMUL;
        cmd.hsel  = 2'd2;
        state_nxt = S_H3;
      end
      S_H3: begin
        cmd.op    = OP_HMUL;
        cmd.hsel  = 2'd3;
        state_nxt = S_H4;
      end
      S_H4: begin
        cmd.op    = OP_HACC;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.op    = OP_EMIT;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: sv/bci_dp.sv
`timescale 1ns / 1ps
// Datapath: point memory, scan trackers, serial divider, shared multiplier
// and result register. Depends on bci_pkg; commanded by bci_ctrl.
module bci_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  bci_pkg::req_t in_req,
  input  bci_pkg::cmd_t cmd,
  output bci_pkg::sts_t sts,
  output logic          out_strobe,
  output bci_pkg::res_t out_res
);
  import bci_pkg::*;

  localparam logic signed [37:0] HERM_ONE = 38'sh1_0000_0000;
  localparam logic signed [59:0] HERM_RND = 60'sh1_0000_0000;

  entry_t mem [MAX_POINTS];
  entry_t rd_r;

  req_t              req_r;
  logic [POS_W-1:0]  key_r;
  logic [CNT_W-1:0]  cnt_r, idx_r, le_cnt_r;
  logic [1:0]        status_r, gt_cnt_r;
  logic              phase2_r, exact_r, bd_v_r;
  logic [KIND_W-1:0] mv_kind_r, ex_kind_r, kind_a_r;
  logic [ADDR_W-1:0] ex_idx_r, best_r;
  logic [VAL_W-1:0]  ex_val_r, vm1_r, va_r, vb_r, vc_r;
  logic [POS_W-1:0]  pos_a_r, pos_b_r, bd_r;
  logic [POS_W-1:0]  r_r, d_r, rem_r;
  logic [3:0]        div_cnt_r;
  logic [15:0]       t_r;
  logic [31:0]       t2_r, t3_r;
  logic [16:0]       w_r;
  logic signed [57:0] prod_r;
  logic signed [59:0] acc_r;
  logic              out_strobe_r;
  res_t              out_res_r;

  // decodes
  logic is_insert, is_remove, is_move1, is_setk, is_clear, is_eval;
  logic [KIND_W-1:0] kind_ins;
  entry_t            ex_data, put_data;
  logic [POS_W-1:0]  pos_dist;
  logic [32:0]       two;

  assign is_insert = (req_r.mode == MODE_INSERT) || phase2_r;
  assign is_move1  = (req_r.mode == MODE_MOVE) && !phase2_r;
  assign is_remove = (req_r.mode == MODE_REMOVE);
  assign is_setk   = (req_r.mode == MODE_SETK);
  assign is_clear  = (req_r.mode == MODE_CLEAR);
  assign is_eval   = (req_r.mode == MODE_EVAL);
  assign kind_ins  = phase2_r ? mv_kind_r : req_r.interp_kind;

  assign pos_dist = (rd_r.pos > key_r) ? (rd_r.pos - key_r) : (key_r - rd_r.pos);
  assign two      = {rem_r, 1'b0};

  always_comb begin
    sts.is_insert = is_insert;
    sts.is_remove = is_remove;
    sts.is_move1  = is_move1;
    sts.is_eval   = is_eval;
    sts.exact     = exact_r;
    sts.full      = (cnt_r == CNT_W'(MAX_POINTS));
    sts.tol_ok    = bd_v_r && (bd_r <= req_r.tolerance);
    sts.same_pos  = (req_r.new_position == req_r.position);
    sts.interp    = (le_cnt_r != '0) && !exact_r && (gt_cnt_r != 2'd0);
    sts.herm      = (kind_a_r == KIND_HERMITE);
    sts.at_ins    = (idx_r == le_cnt_r);
    sts.er_end    = ({1'b0, idx_r} + (CNT_W+1)'(1)) >= {1'b0, cnt_r};
    sts.scan_end  = (idx_r == cnt_r);
    sts.div_last  = (div_cnt_r == 4'd15);
  end

  // write data for an in-place update of the matched point and for a new point
  always_comb begin
    ex_data.pos  = key_r;
    ex_data.val  = req_r.point_value;
    ex_data.kind = kind_ins;
    if (is_move1) begin
      ex_data.kind = ex_kind_r;
    end else if (is_setk) begin
      ex_data.val  = ex_val_r;
      ex_data.kind = req_r.interp_kind;
    end
    put_data.pos  = key_r;
    put_data.val  = req_r.point_value;
    put_data.kind = kind_ins;
  end

  // memory port control
  logic              rd_en, wr_en;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  entry_t            wr_data;
  logic [CNT_W-1:0]  idx_dn, idx_up;

  assign idx_dn = idx_r - CNT_W'(1);
  assign idx_up = idx_r + CNT_W'(1);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_r[ADDR_W-1:0];
    wr_en   = 1'b0;
    wr_addr = idx_r[ADDR_W-1:0];
    wr_data = rd_r;
    unique case (cmd.op)
      OP_SCAN_RD: begin
        rd_en = 1'b1;
      end
      OP_SH_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx_dn[ADDR_W-1:0];
      end
      OP_ER_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx_up[ADDR_W-1:0];
      end
      OP_SH_WR, OP_ER_WR: begin
        wr_en = 1'b1;
      end
      OP_PUT: begin
        wr_en   = 1'b1;
        wr_addr = le_cnt_r[ADDR_W-1:0];
        wr_data = put_data;
      end
      OP_DECIDE: begin
        wr_en   = exact_r && (is_insert || (is_move1 && sts.same_pos) || is_setk);
        wr_addr = ex_idx_r;
        wr_data = ex_data;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // shared multiplier operands
  logic signed [19:0] va_s, vb_s, vc_s, vm1_s, dab2, m0, m1;
  logic signed [37:0] t1_s, t2_s, t3_s, h00, h01, h10, h11;
  logic signed [37:0] mul_a;
  logic signed [19:0] mul_b;
  logic signed [57:0] mul_p;
  logic [17:0]        smooth_k;

  assign va_s  = $signed({4'd0, va_r});
  assign vb_s  = $signed({4'd0, vb_r});
  assign vc_s  = $signed({4'd0, vc_r});
  assign vm1_s = $signed({4'd0, vm1_r});
  assign dab2  = (vb_s - va_s) <<< 1;
  assign m0    = (le_cnt_r >= CNT_W'(2)) ? (vb_s - vm1_s) : dab2;
  assign m1    = (gt_cnt_r == 2'd2) ? (vc_s - va_s) : dab2;

  assign t1_s = $signed({6'd0, t_r, 16'd0});
  assign t2_s = $signed({6'd0, t2_r});
  assign t3_s = $signed({6'd0, t3_r});
  assign h00  = (t3_s <<< 1) - t2_s - (t2_s <<< 1) + HERM_ONE;
  assign h01  = t2_s + (t2_s <<< 1) - (t3_s <<< 1);
  assign h10  = t3_s - (t2_s <<< 1) + t1_s;
  assign h11  = t3_s - t2_s;

  assign smooth_k = 18'h30000 - {1'b0, t_r, 1'b0};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_SQ: begin
        mul_a = $signed({22'd0, t_r});
        mul_b = $signed({4'd0, t_r});
      end
      OP_T2: begin
        mul_a = $signed({6'd0, prod_r[31:0]});
        mul_b = sts.herm ? $signed({4'd0, t_r}) : $signed({2'd0, smooth_k});
      end
      OP_BLEND: begin
        mul_a = 38'(vb_s - va_s);
        mul_b = $signed({3'd0, w_r});
      end
      OP_HMUL: begin
        unique case (cmd.hsel)
          2'd0: begin
            mul_a = h00;
            mul_b = va_s <<< 1;
          end
          2'd1: begin
            mul_a = h01;
            mul_b = vb_s <<< 1;
          end
          2'd2: begin
            mul_a = h10;
            mul_b = m0;
          end
          2'd3: begin
            mul_a = h11;
            mul_b = m1;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // weights
  logic [32:0] easein_s;
  logic [33:0] easeout_s;
  logic [57:0] smooth_s;
  logic [57:0] t3_s_sum;
  logic [16:0] w_nxt;

  assign easein_s  = {1'b0, t2_r} + 33'd32768;
  assign easeout_s = {1'b0, t_r, 17'd0} - {2'd0, t2_r} + 34'd32768;
  assign smooth_s  = prod_r + 58'sd2147483648;
  assign t3_s_sum  = prod_r + 58'sd32768;

  always_comb begin
    unique case (kind_a_r)
      KIND_LINEAR:              w_nxt = {1'b0, t_r};
      KIND_EASEIN:              w_nxt = easein_s[32:16];
      KIND_EASEOUT:             w_nxt = easeout_s[32:16];
      KIND_SMOOTH, KIND_BEZIER: w_nxt = smooth_s[48:32];
      default:                  w_nxt = '0;
    endcase
  end

  // final curve value
  logic signed [57:0] bsum;
  logic signed [59:0] prod_x, hsum;
  logic [26:0]        hw;
  logic [POS_W-1:0]   rem_span;
  logic [41:0]        rem_x1000;
  logic [15:0]        herm_v, hold_v, curve;

  assign bsum      = $signed({26'd0, va_r, 16'd0}) + prod_r + 58'sd32768;
  assign prod_x    = 60'(prod_r);
  assign hsum      = acc_r + HERM_RND;
  assign hw        = hsum[59:33];
  assign herm_v    = acc_r[59] ? 16'd0 : ((hw > 27'd65535) ? 16'hFFFF : hw[15:0]);
  assign rem_span  = r_r - d_r;
  // hold while t < 0.999, i.e. 1000 * (r - d) > r
  assign rem_x1000 = {10'd0, rem_span} * 42'd1000;
  assign hold_v    = (rem_x1000 > {10'd0, r_r}) ? va_r : vb_r;

  always_comb begin
    curve = '0;
    if (is_eval && (cnt_r != '0)) begin
      priority if (le_cnt_r == '0) begin
        curve = vb_r;
      end else if (exact_r || (gt_cnt_r == 2'd0)) begin
        curve = va_r;
      end else begin
        unique case (kind_a_r)
          KIND_STEP:    curve = va_r;
          KIND_HOLD:    curve = hold_v;
          KIND_HERMITE: curve = herm_v;
          default:      curve = bsum[31:16];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      idx_r        <= '0;
      status_r     <= STAT_DONE;
      phase2_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (cmd.op)
        OP_LOAD: begin
          req_r    <= in_req;
          key_r    <= in_req.position;
          status_r <= STAT_DONE;
          phase2_r <= 1'b0;
          idx_r    <= '0;
          exact_r  <= 1'b0;
          bd_v_r   <= 1'b0;
          le_cnt_r <= '0;
          gt_cnt_r <= 2'd0;
        end
        OP_SCAN_CHK: begin
          if (rd_r.pos == key_r) begin
            exact_r   <= 1'b1;
            ex_idx_r  <= idx_r[ADDR_W-1:0];
            ex_val_r  <= rd_r.val;
            ex_kind_r <= rd_r.kind;
          end
          if (rd_r.pos <= key_r) begin
            le_cnt_r <= le_cnt_r + CNT_W'(1);
            vm1_r    <= va_r;
            va_r     <= rd_r.val;
            pos_a_r  <= rd_r.pos;
            kind_a_r <= rd_r.kind;
          end else begin
            if (gt_cnt_r == 2'd0) begin
              vb_r    <= rd_r.val;
              pos_b_r <= rd_r.pos;
            end
            if (gt_cnt_r == 2'd1) begin
              vc_r <= rd_r.val;
            end
            if (gt_cnt_r != 2'd2) begin
              gt_cnt_r <= gt_cnt_r + 2'd1;
            end
          end
          // strict compare keeps the lower index on a tie
          if (!bd_v_r || (pos_dist < bd_r)) begin
            bd_v_r <= 1'b1;
            bd_r   <= pos_dist;
            best_r <= idx_r[ADDR_W-1:0];
          end
          idx_r <= idx_up;
        end
        OP_DECIDE: begin
          if (is_insert) begin
            if (!exact_r && sts.full) begin
              status_r <= STAT_FULL;
            end else if (!exact_r) begin
              idx_r <= cnt_r;
            end
          end else if (is_remove) begin
            if (sts.tol_ok) begin
              idx_r <= {1'b0, best_r};
            end else begin
              status_r <= STAT_NOMATCH;
            end
          end else if (is_move1) begin
            if (!exact_r) begin
              status_r <= STAT_NOMATCH;
            end else if (!sts.same_pos) begin
              idx_r     <= {1'b0, ex_idx_r};
              mv_kind_r <= ex_kind_r;
            end
          end else if (is_setk) begin
            if (!exact_r) begin
              status_r <= STAT_NOMATCH;
            end
          end else if (is_clear) begin
            cnt_r <= '0;
          end
        end
        OP_SH_WR: begin
          idx_r <= idx_dn;
        end
        OP_PUT: begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
        OP_ER_WR: begin
          idx_r <= idx_up;
        end
        OP_ER_END: begin
          cnt_r <= cnt_r - CNT_W'(1);
          if (is_move1) begin
            phase2_r <= 1'b1;
            key_r    <= req_r.new_position;
            idx_r    <= '0;
            exact_r  <= 1'b0;
            bd_v_r   <= 1'b0;
            le_cnt_r <= '0;
            gt_cnt_r <= 2'd0;
          end
        end
        OP_EV_INIT: begin
          d_r       <= key_r - pos_a_r;
          rem_r     <= key_r - pos_a_r;
          r_r       <= pos_b_r - pos_a_r;
          t_r       <= '0;
          div_cnt_r <= '0;
        end
        OP_DIV: begin
          if (two >= {1'b0, r_r}) begin
            rem_r <= 32'(two - {1'b0, r_r});
            t_r   <= {t_r[14:0], 1'b1};
          end else begin
            rem_r <= two[31:0];
            t_r   <= {t_r[14:0], 1'b0};
          end
          div_cnt_r <= div_cnt_r + 4'd1;
        end
        OP_SQ: begin
          prod_r <= mul_p;
        end
        OP_T2: begin
          t2_r   <= prod_r[31:0];
          prod_r <= mul_p;
        end
        OP_WGT: begin
          w_r  <= w_nxt;
          t3_r <= t3_s_sum[47:16];
        end
        OP_BLEND: begin
          prod_r <= mul_p;
        end
        OP_HMUL: begin
          prod_r <= mul_p;
          if (cmd.hsel == 2'd1) begin
            acc_r <= prod_x;
          end else if (cmd.hsel != 2'd0) begin
            acc_r <= acc_r + prod_x;
          end
        end
        OP_HACC: begin
          acc_r <= acc_r + prod_x;
        end
        OP_EMIT: begin
          out_strobe_r          <= 1'b1;
          out_res_r.curve_value <= curve;
          out_res_r.status      <= status_r;
          out_res_r.point_count <= cnt_r;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

endmodule

// File: sv/breakpoint_curve_interpolator_unit.sv
`timescale 1ns / 1ps
// Top level of the breakpoint curve interpolator: controller plus datapath.
// Depends on bci_pkg, bci_ctrl and bci_dp.
//
// One request is taken when start is high and busy is low; its single result
// appears on out_res for one cycle with out_strobe high, in the cycle in which
// busy falls, and cannot be held off. Every request first scans the stored
// points through the single memory read port, with a read and a check per
// point. Insert then shifts later points up and remove or move shift them down,
// with a read and a write per moved point; a move scans a second time for its
// target. An interpolated evaluate adds a serial divide for the 16-bit fraction
// t and then setup and multiplies. The longest request is a move of the first
// point to a new first position.
module breakpoint_curve_interpolator_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  bci_pkg::req_t in_req,
  output logic          out_strobe,
  output bci_pkg::res_t out_res
);
  import bci_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bci_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  bci_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_req),
    .cmd        (cmd),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

endmodule

// File: sim/breakpoint_curve_interpolator_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for breakpoint_curve_interpolator_unit: directed and random requests,
// each checked against an in-bench model of the breakpoint table.
// Depends on bci_pkg and the RTL of the unit.
module breakpoint_curve_interpolator_unit_tb;
  import bci_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  req_t in_req = '0;
  logic busy;
  logic out_strobe;
  res_t out_res;

  breakpoint_curve_interpolator_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

  // model of the breakpoint table
  logic [POS_W-1:0]  curve_pos  [MAX_POINTS];
  logic [VAL_W-1:0]  curve_val  [MAX_POINTS];
  logic [KIND_W-1:0] curve_kind [MAX_POINTS];
  int unsigned       curve_cnt = 0;

  res_t pending_results[$];
  bit   failed = 1'b0;
  int   idle_pct = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #60ms;
    $display("status: fail");
    $finish;
  end

  function automatic int find_point(logic [POS_W-1:0] p);
    for (int i = 0; i < curve_cnt; i++) if (curve_pos[i] == p) return i;
    return -1;
  endfunction

  function automatic void erase_point(int at);
    for (int i = at; i + 1 < curve_cnt; i++) begin
      curve_pos[i]  = curve_pos[i+1];
      curve_val[i]  = curve_val[i+1];
      curve_kind[i] = curve_kind[i+1];
    end
    curve_cnt--;
  endfunction

  function automatic logic [1:0] insert_point(logic [POS_W-1:0] p, logic [VAL_W-1:0] v,
                                              logic [KIND_W-1:0] k);
    int e;
    int at;
    e = find_point(p);
    at = 0;
    if (e >= 0) begin
      curve_val[e] = v;
      curve_kind[e] = k;
      return STAT_DONE;
    end
    if (curve_cnt >= MAX_POINTS) return STAT_FULL;
    while (at < curve_cnt && curve_pos[at] <= p) at++;
    for (int i = curve_cnt; i > at; i--) begin
      curve_pos[i]  = curve_pos[i-1];
      curve_val[i]  = curve_val[i-1];
      curve_kind[i] = curve_kind[i-1];
    end
    curve_pos[at] = p;
    curve_val[at] = v;
    curve_kind[at] = k;
    curve_cnt++;
    return STAT_DONE;
  endfunction

  function automatic logic [15:0] curve_at(logic [POS_W-1:0] x);
    int pi;
    longint unsigned d, r, rem, tq, w, a, b;
    longint t1, t2, t3, h00, h10, h01, h11, m0, m1, s, one;
    pi = 0;
    tq = 0;
    if (curve_cnt == 0) return '0;
    if (curve_cnt == 1 || x < curve_pos[0]) return curve_val[0];
    for (int i = 0; i < curve_cnt; i++) begin
      if (curve_pos[i] <= x) pi = i;
      else break;
    end
    if (curve_pos[pi] == x || pi + 1 >= curve_cnt) return curve_val[pi];
    a = curve_val[pi];
    b = curve_val[pi+1];
    d = x - curve_pos[pi];
    r = curve_pos[pi+1] - curve_pos[pi];
    rem = d;
    for (int i = 0; i < 16; i++) begin
      tq = tq << 1;
      if (rem >= r - rem) begin
        rem = rem - (r - rem);
        tq = tq | 1;
      end else begin
        rem = rem << 1;
      end
    end
    case (curve_kind[pi])
      KIND_STEP:    return a[15:0];
      KIND_LINEAR:  w = tq;
      KIND_EASEIN:  w = (tq * tq + 32768) >> 16;
      KIND_EASEOUT: w = (tq * (131072 - tq) + 32768) >> 16;
      KIND_HOLD:    return ((r - d) > r / 1000) ? a[15:0] : b[15:0];
      KIND_HERMITE: begin
        one = 64'sd1 <<< 32;
        t1 = longint'(tq << 16);
        t2 = longint'(tq * tq);
        t3 = longint'((tq * tq * tq + 32768) >> 16);
        h00 = 2 * t3 - 3 * t2 + one;
        h10 = t3 - 2 * t2 + t1;
        h01 = -2 * t3 + 3 * t2;
        h11 = t3 - t2;
        m0 = (pi > 0) ? longint'(b) - longint'(curve_val[pi-1])
                      : 2 * (longint'(b) - longint'(a));
        m1 = (pi + 2 < curve_cnt) ? longint'(curve_val[pi+2]) - longint'(a)
                                  : 2 * (longint'(b) - longint'(a));
        s = 2 * (h00 * longint'(a) + h01 * longint'(b)) + h10 * m0 + h11 * m1;
        if (s < 0) return '0;
        w = (longint'(s) + (64'd1 << 32)) >> 33;
        return (w > 65535) ? 16'hFFFF : w[15:0];
      end
      default:      w = (tq * tq * (3 * 65536 - 2 * tq) + 64'h8000_0000) >> 32;
    endcase
    w = (a * (65536 - w) + b * w + 32768) >> 16;
    return w[15:0];
  endfunction

  function automatic res_t predict_result(req_t q);
    res_t res;
    int e;
    int best;
    longint unsigned bd, dd;
    logic [KIND_W-1:0] k;
    res = '0;
    case (q.mode)
      MODE_INSERT: res.status = insert_point(q.position, q.point_value, q.interp_kind);
      MODE_REMOVE: begin
        best = 0;
        bd = '1;
        res.status = STAT_NOMATCH;
        for (int i = 0; i < curve_cnt; i++) begin
          dd = (curve_pos[i] > q.position) ? curve_pos[i] - q.position
                                          : q.position - curve_pos[i];
          if (dd < bd) begin
            bd = dd;
            best = i;
          end
        end
        if (curve_cnt > 0 && bd <= q.tolerance) begin
          erase_point(best);
          res.status = STAT_DONE;
        end
      end
      MODE_MOVE: begin
        e = find_point(q.position);
        if (e < 0) res.status = STAT_NOMATCH;
        else if (q.new_position == q.position) curve_val[e] = q.point_value;
        else begin
          k = curve_kind[e];
          erase_point(e);
          void'(insert_point(q.new_position, q.point_value, k));
        end
      end
      MODE_SETK: begin
        e = find_point(q.position);
        if (e < 0) res.status = STAT_NOMATCH;
        else curve_kind[e] = q.interp_kind;
      end
      MODE_CLEAR: curve_cnt = 0;
      MODE_EVAL:  res.curve_value = curve_at(q.position);
      default: ;
    endcase
    res.point_count = curve_cnt[6:0];
    return res;
  endfunction

  // hold start until the request is taken, then maybe idle
  task automatic send_request(req_t q);
    start <= 1'b1;
    in_req <= q;
    do @(posedge clk); while (busy);
    pending_results = {pending_results, predict_result(q)};
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic req_t make_req(logic [MODE_W-1:0] m, logic [31:0] p, logic [31:0] np,
                                    logic [15:0] v, logic [2:0] k, logic [31:0] tol);
    req_t q;
    q.mode = m;
    q.position = p;
    q.new_position = np;
    q.point_value = v;
    q.interp_kind = k;
    q.tolerance = tol;
    return q;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_res);
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        if (out_res.curve_value !== want.curve_value) begin
          $display("%0t: curve_value expected %h got %h", $time, want.curve_value,
                   out_res.curve_value);
          failed = 1'b1;
        end
        if (out_res.status !== want.status) begin
          $display("%0t: status expected %h got %h", $time, want.status, out_res.status);
          failed = 1'b1;
        end
        if (out_res.point_count !== want.point_count) begin
          $display("%0t: point_count expected %0d got %0d", $time, want.point_count,
                   out_res.point_count);
          failed = 1'b1;
        end
      end
    end
  end

  // drop start once the last request is in, then wait for every result
  task automatic drain_results();
    @(posedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // empty table, field extremes, spare modes, misses
  task automatic test_edges();
    send_request(make_req(MODE_EVAL, 32'hFFFF_FFFF, '1, '1, '1, '1));
    send_request(make_req(MODE_REMOVE, 32'd5, '0, '0, '0, '1));
    send_request(make_req(MODE_INSERT, 32'd0, '0, 16'h0000, KIND_LINEAR, '0));
    send_request(make_req(MODE_INSERT, 32'hFFFF_FFFF, '1, 16'hFFFF, KIND_HERMITE, '1));
    send_request(make_req(MODE_EVAL, 32'h8000_0000, '0, '0, '0, '0));
    send_request(make_req(MODE_EVAL, 32'hFFFF_FFFF, '0, '0, '0, '0));
    send_request(make_req(MODE_INSERT, 32'd0, '0, 16'h1234, KIND_EASEIN, '0));
    send_request(make_req(MODE_MOVE, 32'd7, 32'd9, '0, '0, '0));
    send_request(make_req(MODE_SETK, 32'd7, '0, '0, KIND_STEP, '0));
    send_request(make_req(MODE_SPARE6, '1, '1, '1, '1, '1));
    send_request(make_req(MODE_SPARE7, '0, '0, '0, '0, '0));
    send_request(make_req(MODE_CLEAR, '1, '1, '1, '1, '1));
    drain_results();
  endtask

  // one segment evaluated under every kind, then a hermite overshoot
  task automatic test_kinds();
    send_request(make_req(MODE_INSERT, 32'd1000, '0, 16'd1000, KIND_STEP, '0));
    send_request(make_req(MODE_INSERT, 32'd2000, '0, 16'd60000, KIND_STEP, '0));
    for (int k = 0; k < 8; k++) begin
      send_request(make_req(MODE_SETK, 32'd1000, '0, '0, k[2:0], '0));
      send_request(make_req(MODE_EVAL, 32'd1300, '0, '0, '0, '0));
    end
    // hold flips right at t = 0.999
    send_request(make_req(MODE_SETK, 32'd1000, '0, '0, KIND_HOLD, '0));
    send_request(make_req(MODE_EVAL, 32'd1999, '0, '0, '0, '0));
    send_request(make_req(MODE_EVAL, 32'd1998, '0, '0, '0, '0));
    send_request(make_req(MODE_INSERT, 32'd500, '0, 16'd65535, KIND_HERMITE, '0));
    send_request(make_req(MODE_INSERT, 32'd2500, '0, 16'd0, KIND_HERMITE, '0));
    send_request(make_req(MODE_SETK, 32'd1000, '0, '0, KIND_HERMITE, '0));
    send_request(make_req(MODE_EVAL, 32'd600, '0, '0, '0, '0));
    send_request(make_req(MODE_EVAL, 32'd1900, '0, '0, '0, '0));
    send_request(make_req(MODE_EVAL, 32'd100, '0, '0, '0, '0));
    drain_results();
  endtask

  // remove ties, move onto an occupied position, move in place
  task automatic test_edit();
    send_request(make_req(MODE_REMOVE, 32'd1500, '0, '0, '0, 32'd500));
    send_request(make_req(MODE_MOVE, 32'd1000, 32'd2500, 16'd77, '0, '0));
    send_request(make_req(MODE_MOVE, 32'd2500, 32'd2500, 16'd88, '0, '0));
    send_request(make_req(MODE_REMOVE, 32'd1, '0, '0, '0, 32'd10));
    send_request(make_req(MODE_CLEAR, '0, '0, '0, '0, '0));
    drain_results();
  endtask

  // fill the table and insert into it while full
  task automatic test_full_table();
    while (curve_cnt < MAX_POINTS)
      send_request(make_req(MODE_INSERT, $urandom, '0, 16'($urandom), 3'($urandom), '0));
    send_request(make_req(MODE_INSERT, $urandom, $urandom, 16'($urandom), 3'($urandom), '0));
    send_request(make_req(MODE_INSERT, curve_pos[9], '0, 16'h5A5A, KIND_SMOOTH, '0));
    for (int i = 0; i < 20; i++)
      send_request(make_req(MODE_EVAL, $urandom, '0, '0, '0, '0));
    send_request(make_req(MODE_CLEAR, '0, '0, '0, '0, '0));
  endtask

  function automatic logic [31:0] pick_position(int unsigned span);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (curve_cnt > 0 && sel < 40) return curve_pos[$urandom_range(0, curve_cnt - 1)];
    if (sel < 90) return $urandom_range(0, span);
    return $urandom;
  endfunction

  task automatic test_random(int unsigned n_req, int unsigned span);
    req_t q;
    int unsigned sel;
    for (int i = 0; i < n_req; i++) begin
      sel = $urandom_range(0, 99);
      q.position = pick_position(span);
      q.new_position = pick_position(span);
      q.point_value = 16'($urandom);
      q.interp_kind = 3'($urandom);
      case ($urandom_range(0, 3))
        0: q.tolerance = '0;
        1: q.tolerance = $urandom;
        default: q.tolerance = $urandom_range(0, span / 8);
      endcase
      if (sel < 30) q.mode = MODE_INSERT;
      else if (sel < 40) q.mode = MODE_REMOVE;
      else if (sel < 48) q.mode = MODE_MOVE;
      else if (sel < 54) q.mode = MODE_SETK;
      else if (sel < 55) q.mode = MODE_CLEAR;
      else if (sel < 97) q.mode = MODE_EVAL;
      else q.mode = sel[0] ? MODE_SPARE6 : MODE_SPARE7;
      send_request(q);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edges();
    idle_pct = 51;
    test_kinds();
    idle_pct = 0;
    test_edit();
    idle_pct = 17;
    test_full_table();
    idle_pct = 0;
    test_random(450, 4000);
    idle_pct = 51;
    test_random(450, 200000);
    idle_pct = 17;
    test_random(450, 300);
    idle_pct = 0;
    test_random(400, 1 << 20);
    start <= 1'b0;
    drain_results();
    repeat (320) @(posedge clk);
    if (!failed) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
